// ===== rtl/core/tpls_pkg.sv =====
package tpls_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int NUM_CH         = 3;
   localparam int CH_BITS        = 2;
   localparam int COLOR_BITS     = 8;
   localparam int STR_BITS       = 9;
   localparam int RANGE_BITS     = 16;
   localparam int FALL_BITS      = 17;
   localparam int CS_BITS        = 16;
   localparam int DIV_STEPS      = 17;
   localparam int AMB_SHIFT      = 8;
   localparam int FALL_SHIFT     = 24;
   localparam int STR_ONE        = 256;
   localparam int FALL_ONE       = 65536;
   localparam int COLOR_MAX      = 255;
   localparam int CSR_DATA_BITS  = 9;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CH_BITS-1:0] CH_RED   = 2'd0;
   localparam logic [CH_BITS-1:0] CH_GREEN = 2'd1;
   localparam logic [CH_BITS-1:0] CH_BLUE  = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AMB_RED,
      CSR_AMB_GREEN,
      CSR_AMB_BLUE,
      CSR_AMB_STRENGTH
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0]          tile_x;
      logic signed [15:0]          tile_y;
      logic signed [15:0]          light_x;
      logic signed [15:0]          light_y;
      logic [RANGE_BITS-1:0]       light_range;
      logic [STR_BITS-1:0]         light_strength;
      logic [COLOR_BITS-1:0]       light_red;
      logic [COLOR_BITS-1:0]       light_green;
      logic [COLOR_BITS-1:0]       light_blue;
      logic                        light_present;
      logic                        first_of_tile;
      logic                        last_of_tile;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AMB,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_CHK,
      ST_DIV,
      ST_MCS,
      ST_MFL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      state_type          state;
      logic [CH_BITS-1:0] ch;
      logic               step_first;
      logic               load_rsp;
   } ctl_type;

   typedef struct packed {
      logic first;
      logic present;
      logic last;
      logic in_range;
      logic out_busy;
   } status_type;

endpackage

// ===== rtl/core/tile_point_light_shading.sv =====
// Steps per item: ambient (each channel with the first flag, red only without), then for a lit
// item the two squares, the root and the range check, and if the light reaches the tile the
// falloff divide and a color-strength and a falloff multiply per channel; then emit. Items are
// taken one at a time: req_stall stays high until the item is done, and longer while a result
// waits on rsp_stall; one shared multiplier, and one subtractor for the root and the 17-step falloff divide.
// Reset: synchronous; ambient color clears to 0, ambient strength to 1.0, accumulator to 0.
module tile_point_light_shading #(
   parameter int COORD_BITS = tpls_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tpls_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tpls_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_wen,
   input  logic [tpls_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tpls_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int MAG_BITS = COORD_BITS + 1;
   localparam int RW       = COORD_BITS + 2;
   localparam int QW       = 2 * RW;
   localparam int REM_BITS = RW + 2;
   localparam int FB       = tpls_pkg::FALL_BITS;
   localparam int MW       = (MAG_BITS > FB) ? MAG_BITS : FB;
   localparam int SW       = (REM_BITS > FB) ? REM_BITS : FB;
   localparam int CW       = (RW > tpls_pkg::RANGE_BITS) ? RW : tpls_pkg::RANGE_BITS;
   localparam int CB       = tpls_pkg::COLOR_BITS;

   tpls_pkg::ctl_type    ctl;
   tpls_pkg::status_type status;

   logic signed [COORD_BITS-1:0] tx, ty, lx, ly;
   logic signed [MAG_BITS-1:0]   dx_s, dy_s;
   logic [MAG_BITS-1:0]          mag_x, mag_y;

   tpls_pkg::req_word_type   item_ff;
   logic [MAG_BITS-1:0]      mag_x_ff, mag_y_ff;
   logic [QW-1:0]            sq_ff, rad_ff;
   logic [REM_BITS-1:0]      rem_ff;
   logic [RW-1:0]            root_ff;
   logic [FB-1:0]            div_rem_ff, q_ff;
   logic [tpls_pkg::CS_BITS-1:0] cs_ff;
   logic [CB-1:0]            acc_ff [tpls_pkg::NUM_CH];
   logic [CB-1:0]            amb_color_ff [tpls_pkg::NUM_CH];
   logic [tpls_pkg::STR_BITS-1:0] amb_str_ff;
   logic                     rsp_valid_ff;
   tpls_pkg::rsp_word_type   rsp_word_ff;

   logic [MW-1:0]   mul_a, mul_b;
   logic [2*MW-1:0] mul_p;
   logic [SW-1:0]   sub_a, sub_b, sub_d;
   logic            sub_ge;

   logic                     accept;
   logic [REM_BITS-1:0]      rem_sh;
   logic [REM_BITS-1:0]      trial;
   logic [FB-1:0]            div_t;
   logic [tpls_pkg::STR_BITS-1:0] limit, strength;
   logic [CB-1:0]            item_color;
   logic [CB:0]              amb_raw;
   logic [CB-1:0]            amb_sat;
   logic [CB:0]              light_term;
   logic [CB+1:0]            acc_sum;
   logic [CB-1:0]            acc_sat;

   generate
      if (COORD_BITS <= 16) begin : g_narrow
         assign tx = req_word.tile_x[COORD_BITS-1:0];
         assign ty = req_word.tile_y[COORD_BITS-1:0];
         assign lx = req_word.light_x[COORD_BITS-1:0];
         assign ly = req_word.light_y[COORD_BITS-1:0];
      end else begin : g_wide
         assign tx = COORD_BITS'(req_word.tile_x);
         assign ty = COORD_BITS'(req_word.tile_y);
         assign lx = COORD_BITS'(req_word.light_x);
         assign ly = COORD_BITS'(req_word.light_y);
      end
   endgenerate

   assign dx_s  = MAG_BITS'(lx) - MAG_BITS'(tx);
   assign dy_s  = MAG_BITS'(ly) - MAG_BITS'(ty);
   assign mag_x = dx_s[MAG_BITS-1] ? MAG_BITS'(-dx_s) : MAG_BITS'(dx_s);
   assign mag_y = dy_s[MAG_BITS-1] ? MAG_BITS'(-dy_s) : MAG_BITS'(dy_s);

   assign accept    = (ctl.state == tpls_pkg::ST_IDLE) && req_valid;
   assign req_stall = (ctl.state != tpls_pkg::ST_IDLE);

   assign status.first    = item_ff.first_of_tile;
   assign status.present  = item_ff.light_present;
   assign status.last     = item_ff.last_of_tile;
   assign status.in_range = CW'(root_ff) < CW'(item_ff.light_range);
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   tpls_ctrl #(
      .ROOT_STEPS(RW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .status   (status),
      .ctl      (ctl)
   );

   tpls_alu #(
      .MW(MW),
      .SW(SW)
   ) u_alu (
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p),
      .sub_a (sub_a),
      .sub_b (sub_b),
      .sub_d (sub_d),
      .sub_ge(sub_ge)
   );

   // one radicand digit pair per root step, one quotient bit per divide step
   assign rem_sh = {rem_ff[RW-1:0], rad_ff[QW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign div_t  = ctl.step_first ? div_rem_ff : {div_rem_ff[FB-2:0], 1'b0};

   assign limit    = amb_str_ff[tpls_pkg::STR_BITS-1] ? '0 :
                     tpls_pkg::STR_BITS'(tpls_pkg::STR_ONE) - amb_str_ff;
   assign strength = (item_ff.light_strength > limit) ? limit : item_ff.light_strength;

   always_comb begin
      case (ctl.ch)
         tpls_pkg::CH_RED:   item_color = item_ff.light_red;
         tpls_pkg::CH_GREEN: item_color = item_ff.light_green;
         default:            item_color = item_ff.light_blue;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      sub_a = '0;
      sub_b = '0;
      unique case (ctl.state)
         tpls_pkg::ST_AMB: begin
            mul_a = MW'(amb_color_ff[ctl.ch]);
            mul_b = MW'(amb_str_ff);
         end
         tpls_pkg::ST_SQX: begin
            mul_a = MW'(mag_x_ff);
            mul_b = MW'(mag_x_ff);
         end
         tpls_pkg::ST_SQY: begin
            mul_a = MW'(mag_y_ff);
            mul_b = MW'(mag_y_ff);
         end
         tpls_pkg::ST_ROOT: begin
            sub_a = SW'(rem_sh);
            sub_b = SW'(trial);
         end
         tpls_pkg::ST_DIV: begin
            sub_a = SW'(div_t);
            sub_b = SW'(item_ff.light_range);
         end
         tpls_pkg::ST_MCS: begin
            mul_a = MW'(item_color);
            mul_b = MW'(strength);
         end
         tpls_pkg::ST_MFL: begin
            mul_a = MW'(cs_ff);
            mul_b = MW'(q_ff);
         end
         default: begin
         end
      endcase
   end

   assign amb_raw    = mul_p[tpls_pkg::AMB_SHIFT + CB : tpls_pkg::AMB_SHIFT];
   assign amb_sat    = amb_raw[CB] ? CB'(tpls_pkg::COLOR_MAX) : amb_raw[CB-1:0];
   assign light_term = mul_p[tpls_pkg::FALL_SHIFT + CB : tpls_pkg::FALL_SHIFT];
   assign acc_sum    = (CB+2)'(acc_ff[ctl.ch]) + (CB+2)'(light_term);
   assign acc_sat    = (acc_sum > (CB+2)'(tpls_pkg::COLOR_MAX)) ?
                       CB'(tpls_pkg::COLOR_MAX) : acc_sum[CB-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff  <= req_word;
         mag_x_ff <= mag_x;
         mag_y_ff <= mag_y;
      end
      case (ctl.state)
         tpls_pkg::ST_SQX: begin
            sq_ff <= QW'(mul_p);
         end
         tpls_pkg::ST_SQY: begin
            rad_ff  <= sq_ff + QW'(mul_p);
            rem_ff  <= '0;
            root_ff <= '0;
         end
         tpls_pkg::ST_ROOT: begin
            rad_ff <= {rad_ff[QW-3:0], 2'b00};
            if (sub_ge) begin
               rem_ff  <= sub_d[REM_BITS-1:0];
               root_ff <= {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[RW-2:0], 1'b0};
            end
         end
         tpls_pkg::ST_CHK: begin
            div_rem_ff <= FB'(CW'(item_ff.light_range) - CW'(root_ff));
            q_ff       <= '0;
         end
         tpls_pkg::ST_DIV: begin
            q_ff       <= {q_ff[FB-2:0], sub_ge};
            div_rem_ff <= sub_ge ? sub_d[FB-1:0] : div_t;
         end
         tpls_pkg::ST_MCS: begin
            cs_ff <= mul_p[tpls_pkg::CS_BITS-1:0];
         end
         default: begin
         end
      endcase
      if (ctl.load_rsp) begin
         rsp_word_ff.red   <= acc_ff[tpls_pkg::CH_RED];
         rsp_word_ff.green <= acc_ff[tpls_pkg::CH_GREEN];
         rsp_word_ff.blue  <= acc_ff[tpls_pkg::CH_BLUE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tpls_pkg::NUM_CH; i++) begin
            acc_ff[i]       <= '0;
            amb_color_ff[i] <= '0;
         end
         amb_str_ff   <= tpls_pkg::STR_BITS'(tpls_pkg::STR_ONE);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.state == tpls_pkg::ST_AMB && item_ff.first_of_tile) begin
            acc_ff[ctl.ch] <= amb_sat;
         end else if (ctl.state == tpls_pkg::ST_MFL) begin
            acc_ff[ctl.ch] <= acc_sat;
         end
         if (csr_wen) begin
            unique case (csr_index)
               tpls_pkg::CSR_AMB_RED:      amb_color_ff[tpls_pkg::CH_RED] <= csr_wdata[CB-1:0];
               tpls_pkg::CSR_AMB_GREEN:    amb_color_ff[tpls_pkg::CH_GREEN] <= csr_wdata[CB-1:0];
               tpls_pkg::CSR_AMB_BLUE:     amb_color_ff[tpls_pkg::CH_BLUE] <= csr_wdata[CB-1:0];
               tpls_pkg::CSR_AMB_STRENGTH: amb_str_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         // load wins over drain so a taken word is replaced at once
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result word overwritten while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again without working the word");

   a_fall_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl.state == tpls_pkg::ST_MCS) |-> (q_ff <= FB'(tpls_pkg::FALL_ONE)))
      else $error("falloff above one");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(ctl.state) == tpls_pkg::ST_EMIT))
      else $error("result raised outside emit");

endmodule

// ===== rtl/core/tpls_alu.sv =====
module tpls_alu #(
   parameter int MW = 17,
   parameter int SW = 17
) (
   input  logic [MW-1:0]   mul_a,
   input  logic [MW-1:0]   mul_b,
   output logic [2*MW-1:0] mul_p,
   input  logic [SW-1:0]   sub_a,
   input  logic [SW-1:0]   sub_b,
   output logic [SW-1:0]   sub_d,
   output logic            sub_ge
);

   logic [SW:0] diff;

   assign mul_p  = (2*MW)'(mul_a) * (2*MW)'(mul_b);
   assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_d  = diff[SW-1:0];
   // no borrow means a >= b
   assign sub_ge = ~diff[SW];

endmodule

// ===== rtl/core/tpls_ctrl.sv =====
module tpls_ctrl #(
   parameter int ROOT_STEPS = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tpls_pkg::status_type status,
   output tpls_pkg::ctl_type    ctl
);

   localparam int MAX_STEPS = (ROOT_STEPS > tpls_pkg::DIV_STEPS) ?
                              ROOT_STEPS : tpls_pkg::DIV_STEPS;
   localparam int CNT_BITS  = $clog2(MAX_STEPS);

   tpls_pkg::state_type         state_ff, state_in;
   logic [tpls_pkg::CH_BITS-1:0] ch_ff, ch_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        load_rsp;
   tpls_pkg::state_type         after_amb;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpls_pkg::ST_IDLE;
         ch_ff    <= tpls_pkg::CH_RED;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      cnt_in    = cnt_ff;
      load_rsp  = 1'b0;
      after_amb = status.present ? tpls_pkg::ST_SQX : tpls_pkg::ST_EMIT;
      unique case (state_ff)
         tpls_pkg::ST_IDLE: begin
            ch_in = tpls_pkg::CH_RED;
            if (req_valid) begin
               state_in = tpls_pkg::ST_AMB;
            end
         end
         tpls_pkg::ST_AMB: begin
            if (!status.first || ch_ff == tpls_pkg::CH_BLUE) begin
               state_in = after_amb;
               ch_in    = tpls_pkg::CH_RED;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         tpls_pkg::ST_SQX: begin
            state_in = tpls_pkg::ST_SQY;
         end
         tpls_pkg::ST_SQY: begin
            state_in = tpls_pkg::ST_ROOT;
            cnt_in   = '0;
         end
         tpls_pkg::ST_ROOT: begin
            if (cnt_ff == CNT_BITS'(ROOT_STEPS - 1)) begin
               state_in = tpls_pkg::ST_CHK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tpls_pkg::ST_CHK: begin
            cnt_in   = '0;
            state_in = status.in_range ? tpls_pkg::ST_DIV : tpls_pkg::ST_EMIT;
         end
         tpls_pkg::ST_DIV: begin
            if (cnt_ff == CNT_BITS'(tpls_pkg::DIV_STEPS - 1)) begin
               state_in = tpls_pkg::ST_MCS;
               ch_in    = tpls_pkg::CH_RED;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tpls_pkg::ST_MCS: begin
            state_in = tpls_pkg::ST_MFL;
         end
         tpls_pkg::ST_MFL: begin
            if (ch_ff == tpls_pkg::CH_BLUE) begin
               state_in = tpls_pkg::ST_EMIT;
            end else begin
               state_in = tpls_pkg::ST_MCS;
               ch_in    = ch_ff + 1'b1;
            end
         end
         tpls_pkg::ST_EMIT: begin
            // a last word holds until the output register is free; others go straight back to idle
            if (!status.last) begin
               state_in = tpls_pkg::ST_IDLE;
            end else if (!status.out_busy) begin
               load_rsp = 1'b1;
               state_in = tpls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpls_pkg::ST_IDLE;
         end
      endcase
   end

   assign ctl.state      = state_ff;
   assign ctl.ch         = ch_ff;
   assign ctl.step_first = (cnt_ff == '0);
   assign ctl.load_rsp   = load_rsp;

endmodule

// ===== sim/tile_point_light_shading_test.sv =====
`timescale 1ns / 100ps

module tile_point_light_shading_test;

   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 64;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASES       = 6;
   localparam int PHASE_WORDS  = 105;

   class shade_board;
      tpls_pkg::rsp_word_type tile_colors[$];
      logic [tpls_pkg::COLOR_BITS-1:0] amb_r, amb_g, amb_b;
      logic [tpls_pkg::STR_BITS-1:0]   amb_s;
      logic [tpls_pkg::COLOR_BITS-1:0] acc_r, acc_g, acc_b;
      int errors;
      int seen;

      function new();
         amb_r = '0;
         amb_g = '0;
         amb_b = '0;
         amb_s = tpls_pkg::STR_ONE;
         acc_r = '0;
         acc_g = '0;
         acc_b = '0;
         errors = 0;
         seen = 0;
      endfunction

      function void load_reg(tpls_pkg::csr_index_type idx,
                             logic [tpls_pkg::CSR_DATA_BITS-1:0] d);
         case (idx)
            tpls_pkg::CSR_AMB_RED:      amb_r = d[tpls_pkg::COLOR_BITS-1:0];
            tpls_pkg::CSR_AMB_GREEN:    amb_g = d[tpls_pkg::COLOR_BITS-1:0];
            tpls_pkg::CSR_AMB_BLUE:     amb_b = d[tpls_pkg::COLOR_BITS-1:0];
            tpls_pkg::CSR_AMB_STRENGTH: amb_s = d;
            default: ;
         endcase
      endfunction

      function logic [tpls_pkg::COLOR_BITS-1:0] ambient_part(
            logic [tpls_pkg::COLOR_BITS-1:0] c);
         longint unsigned v;
         v = (64'(c) * 64'(amb_s)) >> tpls_pkg::AMB_SHIFT;
         return (v > tpls_pkg::COLOR_MAX) ? tpls_pkg::COLOR_BITS'(tpls_pkg::COLOR_MAX)
                                          : tpls_pkg::COLOR_BITS'(v);
      endfunction

      // saturate the channel after adding one light's share
      function logic [tpls_pkg::COLOR_BITS-1:0] add_light(
            logic [tpls_pkg::COLOR_BITS-1:0] acc,
            logic [tpls_pkg::COLOR_BITS-1:0] c,
            longint unsigned str,
            longint unsigned fall);
         longint unsigned s;
         s = 64'(acc) + ((64'(c) * str * fall) >> tpls_pkg::FALL_SHIFT);
         return (s > tpls_pkg::COLOR_MAX) ? tpls_pkg::COLOR_BITS'(tpls_pkg::COLOR_MAX)
                                          : tpls_pkg::COLOR_BITS'(s);
      endfunction

      function longint unsigned int_root(longint unsigned n);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function void note(tpls_pkg::req_word_type w);
         longint dx, dy;
         longint unsigned gap, rng, fall, lim, str;
         tpls_pkg::rsp_word_type col;
         if (w.first_of_tile) begin
            acc_r = ambient_part(amb_r);
            acc_g = ambient_part(amb_g);
            acc_b = ambient_part(amb_b);
         end
         if (w.light_present) begin
            dx = longint'($signed(w.light_x)) - longint'($signed(w.tile_x));
            dy = longint'($signed(w.light_y)) - longint'($signed(w.tile_y));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            gap = int_root(64'(dx * dx + dy * dy));
            rng = 64'(w.light_range);
            if (gap < rng) begin
               fall = ((rng - gap) << 16) / rng;
               lim = (amb_s >= tpls_pkg::STR_ONE) ? 0 : tpls_pkg::STR_ONE - amb_s;
               str = 64'(w.light_strength);
               if (str > lim) str = lim;
               acc_r = add_light(acc_r, w.light_red, str, fall);
               acc_g = add_light(acc_g, w.light_green, str, fall);
               acc_b = add_light(acc_b, w.light_blue, str, fall);
            end
         end
         if (w.last_of_tile) begin
            col.red   = acc_r;
            col.green = acc_g;
            col.blue  = acc_b;
            tile_colors.insert(tile_colors.size(), col);
         end
      endfunction

      task report(string msg);
         $display("tile %0d: %s", seen, msg);
         errors++;
      endtask

      task check(tpls_pkg::rsp_word_type got);
         tpls_pkg::rsp_word_type want;
         if (tile_colors.size() == 0) begin
            report($sformatf("unexpected word %0d/%0d/%0d", got.red, got.green, got.blue));
         end else begin
            want = tile_colors.pop_front();
            if (got.red !== want.red)
               report($sformatf("red got %0d, want %0d", got.red, want.red));
            if (got.green !== want.green)
               report($sformatf("green got %0d, want %0d", got.green, want.green));
            if (got.blue !== want.blue)
               report($sformatf("blue got %0d, want %0d", got.blue, want.blue));
         end
         seen++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid;
   logic req_stall;
   tpls_pkg::req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   tpls_pkg::rsp_word_type rsp_word;
   logic csr_wen;
   logic [tpls_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [tpls_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   shade_board board = new();
   int quiet_cycles = 0;
   bit calm = 1'b0;
   bit hold_ask = 1'b0;
   int hold_left = 0;

   tile_point_light_shading dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            board.note(req_word);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check(rsp_word);
            quiet_cycles = 0;
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 19);
         end
      end
   end

   task automatic push_word(input tpls_pkg::req_word_type w);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.tile_colors.size() != 0) @(posedge clock);
   endtask

   // a word without the last flag may still be in flight once the queue is empty
   task automatic settle();
      drain_results();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input tpls_pkg::csr_index_type idx,
                            input logic [tpls_pkg::CSR_DATA_BITS-1:0] d);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      board.load_reg(idx, d);
   endtask

   task automatic set_ambient(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [tpls_pkg::STR_BITS-1:0] s);
      settle();
      write_reg(tpls_pkg::CSR_AMB_RED, {1'b0, r});
      write_reg(tpls_pkg::CSR_AMB_GREEN, {1'b0, g});
      write_reg(tpls_pkg::CSR_AMB_BLUE, {1'b0, b});
      write_reg(tpls_pkg::CSR_AMB_STRENGTH, s);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic tpls_pkg::req_word_type light_word(int tx, int ty, int lx, int ly,
                                                         int rng, int str,
                                                         int r, int g, int b,
                                                         bit present, bit first, bit last);
      tpls_pkg::req_word_type w;
      w.tile_x         = 16'(tx);
      w.tile_y         = 16'(ty);
      w.light_x        = 16'(lx);
      w.light_y        = 16'(ly);
      w.light_range    = 16'(rng);
      w.light_strength = tpls_pkg::STR_BITS'(str);
      w.light_red      = 8'(r);
      w.light_green    = 8'(g);
      w.light_blue     = 8'(b);
      w.light_present  = present;
      w.first_of_tile  = first;
      w.last_of_tile   = last;
      return w;
   endfunction

   function automatic tpls_pkg::req_word_type rand_light(logic [15:0] tx, logic [15:0] ty,
                                                         bit first, bit last);
      tpls_pkg::req_word_type w;
      int span;
      case ($urandom_range(2))
         0: span = 15;
         1: span = 255;
         default: span = 4095;
      endcase
      w.tile_x  = tx;
      w.tile_y  = ty;
      w.light_x = tx + 16'($urandom_range(2 * span) - span);
      w.light_y = ty + 16'($urandom_range(2 * span) - span);
      case ($urandom_range(19))
         0: w.light_range = '0;
         1, 2: w.light_range = 16'($urandom_range(65535));
         3: begin
            w.light_x = 16'($urandom_range(65535));
            w.light_range = 16'($urandom_range(65535));
         end
         default: w.light_range = 16'($urandom_range(2 * span, 1));
      endcase
      w.light_strength = ($urandom_range(3) != 0) ?
                         tpls_pkg::STR_BITS'($urandom_range(tpls_pkg::STR_ONE)) :
                         tpls_pkg::STR_BITS'($urandom_range(511));
      w.light_red     = 8'($urandom_range(255));
      w.light_green   = 8'($urandom_range(255));
      w.light_blue    = 8'($urandom_range(255));
      w.light_present = ($urandom_range(9) != 0);
      w.first_of_tile = first;
      w.last_of_tile  = last;
      return w;
   endfunction

   task automatic send_tile(output int n);
      logic [15:0] tx, ty;
      tx = 16'($urandom_range(65535));
      ty = 16'($urandom_range(65535));
      if ($urandom_range(99) < 15) begin
         // broken run: flags at random
         push_word(rand_light(tx, ty, 1'($urandom_range(1)), 1'($urandom_range(1))));
         n = 1;
      end else begin
         n = $urandom_range(5, 1);
         for (int i = 0; i < n; i++) push_word(rand_light(tx, ty, i == 0, i == n - 1));
      end
   endtask

   function automatic logic [7:0] rand_color();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [tpls_pkg::STR_BITS-1:0] rand_amb_strength();
      case ($urandom_range(5))
         0: return '0;
         1: return tpls_pkg::STR_BITS'(tpls_pkg::STR_ONE);
         2: return tpls_pkg::STR_BITS'(511);
         3: return tpls_pkg::STR_BITS'($urandom_range(511, 257));
         default: return tpls_pkg::STR_BITS'($urandom_range(160));
      endcase
   endfunction

   initial begin : stimulus
      int sent, n;
      bit held, paused;
      req_valid = 1'b0;
      req_word  = '0;
      csr_wen   = 1'b0;
      csr_index = tpls_pkg::CSR_AMB_RED;
      csr_wdata = '0;
      held = 1'b0;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // straight out of reset: emit without a first flag, then a light with no headroom
      push_word(light_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      push_word(light_word(5, 5, 5, 5, 100, 256, 255, 255, 255, 1, 1, 1));

      set_ambient(8'd200, 8'd100, 8'd50, 9'd0);
      push_word(light_word(-32768, 32767, -32768, 32767, 65535, 256, 255, 0, 128, 1, 1, 0));
      push_word(light_word(-32768, 32767, -32768, 32767, 65535, 256, 255, 0, 255, 1, 0, 1));
      push_word(light_word(-32768, -32768, 32767, 32767, 65535, 256, 255, 255, 255, 1, 1, 1));
      push_word(light_word(32767, -32768, -32768, 32767, 65535, 256, 255, 255, 255, 1, 1, 1));
      push_word(light_word(10, 10, 10, 10, 0, 256, 255, 255, 255, 1, 1, 1));
      push_word(light_word(0, 0, 3, 4, 5, 256, 255, 255, 255, 1, 1, 1));
      push_word(light_word(0, 0, 3, -4, 6, 256, 255, 255, 255, 1, 1, 1));
      push_word(light_word(100, 200, 90, 210, 40, 511, 200, 100, 50, 1, 1, 1));
      push_word(light_word(1, 2, 1, 2, 9, 256, 255, 255, 255, 0, 1, 1));
      push_word(light_word(-7, 7, -1, 7, 30, 128, 90, 180, 45, 1, 0, 0));
      push_word(light_word(-7, 7, -7, 1, 30, 128, 90, 180, 45, 1, 0, 1));

      set_ambient(8'd255, 8'd255, 8'd255, 9'd511);
      push_word(light_word(0, 0, 0, 0, 65535, 256, 255, 255, 255, 1, 1, 1));

      set_ambient(8'd17, 8'd128, 8'd255, 9'd300);
      push_word(light_word(0, 0, 1, 1, 1000, 256, 255, 255, 255, 1, 1, 1));

      set_ambient(8'd90, 8'd60, 8'd30, 9'd128);
      push_word(light_word(20, 20, 25, 20, 50, 300, 255, 255, 255, 1, 1, 0));
      push_word(light_word(20, 20, 20, 30, 50, 64, 120, 240, 16, 1, 0, 0));
      push_word(light_word(20, 20, 20, 30, 50, 64, 120, 240, 16, 0, 0, 1));
      push_word(light_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));

      for (int ph = 0; ph < PHASES; ph++) begin
         set_ambient(rand_color(), rand_color(), rand_color(),
                     (ph == 0) ? tpls_pkg::STR_BITS'(0) : rand_amb_strength());
         calm = (ph == 2);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if (ph == 4 && sent >= 20 && !held) begin
               hold_ask = 1'b1;
               held = 1'b1;
            end
            if (ph == 1 && sent >= 50 && !paused) begin
               drain_results();
               paused = 1'b1;
            end
            send_tile(n);
            sent += n;
         end
      end
      calm = 1'b0;

      settle();
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
